@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Item and result layouts, action and status codes, decoded operations and
// the states of the execution sequencer.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH_DEF = 16;   // ring entries by default
	localparam int DATA_W    = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int OCC_W     = 5;
	localparam int QUEUE_D   = 2;    // command queue between front and back

	// action codes of an incoming item
	localparam logic [ACT_W-1:0] ACT_LIST       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd4;

	// status codes of a result
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [DATA_W-1:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] value_out;
		logic                     last_of_run;
		logic [OCC_W-1:0]         occupancy;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_LIST,
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// handshake from the front part to the back part
	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} cmd_chan_t;

	typedef enum logic {
		BK_IDLE,
		BK_LIST
	} back_state_t;

	// control of a result on its way to the output register
	typedef struct packed {
		logic              vld;
		logic              use_mem;
		logic [STAT_W-1:0] status;
		logic              last;
		logic [OCC_W-1:0]  occ;
	} res_ctl_t;

endpackage

@@ rtl/double_ended_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed 32-bit values
// Ring buffer deque with list, push front, push rear, pop front and pop rear.
// ----------------------------------------------------------------------------
// Usage: drive an item on item and raise start; it is taken at an edge where
// busy is low. Every result appears on result for exactly one cycle with
// strobe high, and the receiver cannot stall it, so be ready to capture on
// every cycle. A push or pop yields one result and the block sustains one
// such item per clock while no listing runs; each result passes the command
// queue, memory read register and result register. A listing of N entries
// yields N results on consecutive cycles, front to rear with last_of_run on
// the rear one, and holds the execution sequencer in its list state until
// the rear entry is read, since the entry memory gives one read per cycle;
// busy rises once the two-deep command queue fills behind it. An empty list
// or pop returns status empty, a push into a full queue returns status full
// and changes nothing, and action codes beyond pop rear are taken and dropped
// silently. occupancy gives the entry count after the action, in five bits.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dq_pkg::in_item_t  item,
	output logic              busy,
	output logic              strobe,
	output dq_pkg::out_item_t result
);

	// decoded commands travelling from intake to execution
	dq_pkg::cmd_chan_t chan;
	logic              take;

	// intake: classify the item and hold it until the back part is free
	dq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.chan   (chan),
		.take   (take)
	);

	// execution: ring buffer, pointers and the result register
	dq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.chan   (chan),
		.take   (take),
		.strobe (strobe),
		.result (result)
	);

endmodule

@@ rtl/dq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_front: item intake and classification
// Accepts items, decodes the action into an operation, drops unused codes
// and holds decoded commands in a short queue for the back part.
// ----------------------------------------------------------------------------
module dq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dq_pkg::in_item_t  item,
	output logic              busy,
	output dq_pkg::cmd_chan_t chan,
	input  logic              take
);

	localparam int QPW = $clog2(dq_pkg::QUEUE_D);
	localparam logic [QPW:0] QFULL = (QPW+1)'(dq_pkg::QUEUE_D);

	dq_pkg::cmd_t      queue_q [dq_pkg::QUEUE_D];
	logic [QPW-1:0]    wptr_q;
	logic [QPW-1:0]    rptr_q;
	logic [QPW:0]      cnt_q;
	logic              known;
	dq_pkg::op_t       op;
	logic              push;
	logic              pop;

	always_comb begin
		known = 1'b1;
		op    = dq_pkg::OP_LIST;
		case (item.action)
			dq_pkg::ACT_LIST:       op = dq_pkg::OP_LIST;
			dq_pkg::ACT_PUSH_FRONT: op = dq_pkg::OP_PUSH_FRONT;
			dq_pkg::ACT_PUSH_REAR:  op = dq_pkg::OP_PUSH_REAR;
			dq_pkg::ACT_POP_FRONT:  op = dq_pkg::OP_POP_FRONT;
			dq_pkg::ACT_POP_REAR:   op = dq_pkg::OP_POP_REAR;
			default:                known = 1'b0;
		endcase
	end

	assign busy      = (cnt_q == QFULL);
	assign push      = start && !busy && known;
	assign pop       = take && (cnt_q != '0);
	assign chan.vld  = (cnt_q != '0);
	assign chan.cmd  = queue_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= '{op: op, value: item.value_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPW'(dq_pkg::QUEUE_D - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPW'(dq_pkg::QUEUE_D - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/dq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_back: ring buffer execution
// Carries out decoded commands on the entry memory, keeps front position and
// entry count, and streams listings one entry a cycle into the result register.
// ----------------------------------------------------------------------------
module dq_back #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dq_pkg::cmd_chan_t chan,
	output logic              take,
	output logic              strobe,
	output dq_pkg::out_item_t result
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

	logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];

	dq_pkg::back_state_t               state_q, state_d;
	logic [PW-1:0]                     front_q, front_d;
	logic [CW-1:0]                     count_q, count_d;
	logic [PW-1:0]                     idx_q, idx_d;
	logic                              wr_en, rd_en;
	logic [PW-1:0]                     wr_addr, rd_addr;
	logic signed [dq_pkg::DATA_W-1:0]  rd_data_s1;
	dq_pkg::res_ctl_t                  ctl_d, ctl_s1;
	logic                              strobe_q;
	dq_pkg::out_item_t                 result_q;
	logic                              list_last;

	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
						   input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[PW-1:0];
	endfunction

	assign take      = (state_q == dq_pkg::BK_IDLE);
	assign list_last = ((CW'(idx_q) + 1'b1) == count_q);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		count_d = count_q;
		idx_d   = idx_q;
		wr_en   = 1'b0;
		wr_addr = front_q;
		rd_en   = 1'b0;
		rd_addr = front_q;
		ctl_d   = '0;
		case (state_q)
			dq_pkg::BK_IDLE: begin
				if (chan.vld) begin
					ctl_d.vld    = 1'b1;
					ctl_d.last   = 1'b1;
					ctl_d.status = dq_pkg::ST_DONE;
					case (chan.cmd.op)
						dq_pkg::OP_LIST: begin
							if (count_q == '0) begin
								ctl_d.status = dq_pkg::ST_EMPTY;
							end else begin
								ctl_d.vld = 1'b0;
								idx_d     = '0;
								state_d   = dq_pkg::BK_LIST;
							end
						end
						dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
							if (count_q == FULL_C) begin
								ctl_d.status = dq_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
								if (chan.cmd.op == dq_pkg::OP_PUSH_FRONT) begin
									wr_addr = (front_q == '0) ? LAST_P : front_q - 1'b1;
									front_d = wr_addr;
								end else begin
									wr_addr = ring_add(front_q, count_q);
								end
							end
						end
						dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
							if (count_q == '0) begin
								ctl_d.status = dq_pkg::ST_EMPTY;
							end else begin
								rd_en         = 1'b1;
								ctl_d.use_mem = 1'b1;
								count_d       = count_q - 1'b1;
								if (chan.cmd.op == dq_pkg::OP_POP_FRONT) begin
									rd_addr = front_q;
									front_d = ring_add(front_q, CW'(1));
								end else begin
									rd_addr = ring_add(front_q, count_q - 1'b1);
								end
							end
						end
						default: ctl_d.vld = 1'b0;
					endcase
					ctl_d.occ = dq_pkg::OCC_W'(count_d);
				end
			end
			dq_pkg::BK_LIST: begin
				rd_en         = 1'b1;
				rd_addr       = ring_add(front_q, CW'(idx_q));
				ctl_d.vld     = 1'b1;
				ctl_d.use_mem = 1'b1;
				ctl_d.status  = dq_pkg::ST_DONE;
				ctl_d.last    = list_last;
				ctl_d.occ     = dq_pkg::OCC_W'(count_q);
				idx_d         = idx_q + 1'b1;
				if (list_last) begin
					state_d = dq_pkg::BK_IDLE;
				end
			end
			default: state_d = dq_pkg::BK_IDLE;
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= chan.cmd.value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dq_pkg::BK_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			ctl_s1     <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			ctl_s1     <= ctl_d;
			strobe_q   <= ctl_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			result_q.status      <= ctl_s1.status;
			result_q.value_out   <= ctl_s1.use_mem ? rd_data_s1 : '0;
			result_q.last_of_run <= ctl_s1.last;
			result_q.occupancy   <= ctl_s1.occ;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

@@ verif/double_ended_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb: self-checking bench for the double-ended queue
// Replays a directed set of actions and then random episodes. The episodes
// fill the ring to full, drain it past empty, or mix every action with
// listings. A shadow copy of the ring predicts each result item, and every
// strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

	localparam int RING_DEPTH = dq_pkg::DEPTH_DEF;
	localparam int CLK_HALF   = 4;
	localparam int RESET_CYC  = 11;
	localparam int ITEM_GOAL  = 330;
	localparam int MAX_GAP    = 19;
	// a full listing plus the three-stage pipe, with margin
	localparam int SETTLE_CYC = RING_DEPTH + 12;
	localparam int CYCLE_CAP  = 300000;

	// action codes that the block takes and drops
	localparam logic [dq_pkg::ACT_W-1:0] ACT_SPARE_FIRST = dq_pkg::ACT_POP_REAR + 3'd1;
	localparam logic [dq_pkg::ACT_W-1:0] ACT_SPARE_LAST  = '1;

	localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		dq_pkg::in_item_t item;
		int               gap;        // idle cycles after this item is taken
		bit               wait_drain; // hold off until nothing is awaited
	} pending_item_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	dq_pkg::in_item_t  item   = '0;
	logic              busy;
	logic              strobe;
	dq_pkg::out_item_t result;

	// stimulus waiting to be sent and results still owed by the block
	pending_item_t     send_queue[$];
	dq_pkg::out_item_t awaited_results[$];

	// shadow copy of the ring
	logic signed [dq_pkg::DATA_W-1:0] held_vals [RING_DEPTH];
	int unsigned                      held_front = 0;
	int unsigned                      held_count = 0;

	// generator bookkeeping
	int unsigned gen_count  = 0;
	int          gen_items  = 0;
	bit          burst_mode = 1'b0;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int gap_left       = 0;
	int cur_gap        = 0;

	double_ended_queue_top #(
		.DEPTH(RING_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction: apply one taken item to the shadow ring
	// ------------------------------------------------------------------
	function automatic void owe_result(input logic [dq_pkg::STAT_W-1:0] st,
			input logic signed [dq_pkg::DATA_W-1:0] val, input logic last);
		dq_pkg::out_item_t r;
		r.status      = st;
		r.value_out   = val;
		r.last_of_run = last;
		r.occupancy   = dq_pkg::OCC_W'(held_count);
		awaited_results.push_back(r);
	endfunction

	function automatic void apply_to_shadow(input dq_pkg::in_item_t it);
		logic signed [dq_pkg::DATA_W-1:0] v;
		case (it.action)
			dq_pkg::ACT_LIST: begin
				if (held_count == 0)
					owe_result(dq_pkg::ST_EMPTY, '0, 1'b1);
				else
					for (int unsigned i = 0; i < held_count; i++)
						owe_result(dq_pkg::ST_DONE,
							held_vals[(held_front + i) % RING_DEPTH],
							i + 1 == held_count);
			end
			dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_REAR: begin
				if (held_count >= RING_DEPTH) begin
					owe_result(dq_pkg::ST_FULL, '0, 1'b1);
				end else begin
					if (it.action == dq_pkg::ACT_PUSH_FRONT) begin
						held_front = (held_front + RING_DEPTH - 1) % RING_DEPTH;
						held_vals[held_front] = it.value_in;
					end else begin
						held_vals[(held_front + held_count) % RING_DEPTH] = it.value_in;
					end
					held_count++;
					owe_result(dq_pkg::ST_DONE, '0, 1'b1);
				end
			end
			dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_REAR: begin
				if (held_count == 0) begin
					owe_result(dq_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					if (it.action == dq_pkg::ACT_POP_FRONT) begin
						v = held_vals[held_front];
						held_front = (held_front + 1) % RING_DEPTH;
					end else begin
						v = held_vals[(held_front + held_count - 1) % RING_DEPTH];
					end
					held_count--;
					owe_result(dq_pkg::ST_DONE, v, 1'b1);
				end
			end
			default: ; // spare codes: no result, no change
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
		// lean on the extremes now and then, otherwise any pattern
		if ($urandom_range(0, 7) == 0)
			case ($urandom_range(0, 3))
				0:       return VAL_MAX;
				1:       return VAL_MIN;
				2:       return '0;
				default: return '1;
			endcase
		return $urandom;
	endfunction

	function automatic void queue_item(input logic [dq_pkg::ACT_W-1:0] act,
			input logic signed [dq_pkg::DATA_W-1:0] val, input bit drain);
		pending_item_t p;
		p.item.action   = act;
		p.item.value_in = val;
		p.gap           = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
		p.wait_drain    = drain;
		send_queue.push_back(p);
		// track the fill level only to steer the episodes
		case (act)
			dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_REAR:
				if (gen_count < RING_DEPTH) gen_count++;
			dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_REAR:
				if (gen_count > 0) gen_count--;
			default: ;
		endcase
		if (act <= dq_pkg::ACT_POP_REAR)
			gen_items++;
	endfunction

	function automatic logic [dq_pkg::ACT_W-1:0] any_push();
		return $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_REAR;
	endfunction

	function automatic logic [dq_pkg::ACT_W-1:0] any_pop();
		return $urandom_range(0, 1) ? dq_pkg::ACT_POP_FRONT : dq_pkg::ACT_POP_REAR;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer one item at a time, hold it until taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bit taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				apply_to_shadow(item);
				gap_left = cur_gap;
			end
			if (start && !taken) begin
				// hold the item on the port while busy is high
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (send_queue.size() != 0 &&
					!(send_queue[0].wait_drain && awaited_results.size() != 0)) begin
				item    <= send_queue[0].item;
				start   <= 1'b1;
				cur_gap  = send_queue[0].gap;
				void'(send_queue.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check every strobed result against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		dq_pkg::out_item_t want;
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result item: status %0d value_out %0d occupancy %0d",
					result.status, result.value_out, result.occupancy);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatch_count++;
				end
				if (result.value_out !== want.value_out) begin
					$error("value_out: expected %0d, got %0d", want.value_out,
						result.value_out);
					mismatch_count++;
				end
				if (result.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", want.last_of_run,
						result.last_of_run);
					mismatch_count++;
				end
				if (result.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						result.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	// drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d result items outstanding",
				cycle_count, awaited_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int  n;
		int  pick;
		bit  first_episode;

		// directed: empty cases, extreme values, wrap of the front index
		queue_item(dq_pkg::ACT_LIST, '0, 1'b0);
		queue_item(dq_pkg::ACT_POP_FRONT, VAL_MAX, 1'b0);
		queue_item(dq_pkg::ACT_POP_REAR, VAL_MIN, 1'b0);
		queue_item(dq_pkg::ACT_PUSH_FRONT, VAL_MAX, 1'b0);
		queue_item(dq_pkg::ACT_PUSH_REAR, VAL_MIN, 1'b0);
		queue_item(dq_pkg::ACT_PUSH_FRONT, '1, 1'b0);
		queue_item(dq_pkg::ACT_PUSH_REAR, '0, 1'b0);
		queue_item(dq_pkg::ACT_LIST, '1, 1'b0);
		queue_item(ACT_SPARE_FIRST, VAL_MAX, 1'b0);
		queue_item(ACT_SPARE_FIRST + 3'd1, '1, 1'b0);
		queue_item(ACT_SPARE_LAST, VAL_MIN, 1'b0);
		queue_item(dq_pkg::ACT_POP_FRONT, '0, 1'b0);
		queue_item(dq_pkg::ACT_POP_REAR, '0, 1'b0);
		queue_item(dq_pkg::ACT_LIST, '0, 1'b0);
		queue_item(dq_pkg::ACT_POP_FRONT, '0, 1'b0);
		queue_item(dq_pkg::ACT_POP_REAR, '0, 1'b0);
		queue_item(dq_pkg::ACT_POP_REAR, '0, 1'b0);
		queue_item(dq_pkg::ACT_LIST, '0, 1'b0);

		// random episodes until the item goal is met
		first_episode = 1'b1;
		while (gen_items < ITEM_GOAL) begin
			burst_mode = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 3);
			// the first episode always waits for the ring pipe to empty
			queue_item(dq_pkg::ACT_LIST, '0,
				first_episode || ($urandom_range(0, 3) == 0));
			first_episode = 1'b0;
			case (pick)
				0: begin
					// fill to full, push past it, then list all
					while (gen_count < RING_DEPTH)
						queue_item(any_push(), pick_value(), 1'b0);
					n = $urandom_range(1, 3);
					repeat (n) queue_item(any_push(), pick_value(), 1'b0);
					queue_item(dq_pkg::ACT_LIST, pick_value(), 1'b0);
				end
				1: begin
					// drain to empty, pop past it
					while (gen_count > 0)
						queue_item(any_pop(), pick_value(), 1'b0);
					n = $urandom_range(1, 2);
					repeat (n) queue_item(any_pop(), pick_value(), 1'b0);
					queue_item(dq_pkg::ACT_LIST, pick_value(), 1'b0);
				end
				default: begin
					// mixed traffic with the odd spare code as noise
					n = $urandom_range(8, 30);
					repeat (n) begin
						case ($urandom_range(0, 19))
							0, 1, 2, 3:
								queue_item(dq_pkg::ACT_PUSH_FRONT, pick_value(), 1'b0);
							4, 5, 6, 7:
								queue_item(dq_pkg::ACT_PUSH_REAR, pick_value(), 1'b0);
							8, 9, 10, 11:
								queue_item(dq_pkg::ACT_POP_FRONT, pick_value(), 1'b0);
							12, 13, 14, 15:
								queue_item(dq_pkg::ACT_POP_REAR, pick_value(), 1'b0);
							16, 17, 18:
								queue_item(dq_pkg::ACT_LIST, pick_value(), 1'b0);
							default:
								queue_item(dq_pkg::ACT_W'($urandom_range(
									ACT_SPARE_FIRST, ACT_SPARE_LAST)),
									pick_value(), 1'b0);
						endcase
					end
				end
			endcase
		end

		// release reset once and let the driver run
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every item is sent and every result has arrived
		do
			@(posedge clk);
		while (send_queue.size() != 0 || start || awaited_results.size() != 0);

		// allow for stray results after the last expected one
		repeat (SETTLE_CYC) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
